/* hw/rtl/ilffa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilffa_pkg
// Beat types and tag-word constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ilffa_pkg;

    // tag word: size in bits 20..4, allocated flag in bit 0
    localparam int TAG_W       = 21;
    localparam int REQ_W       = 20;
    localparam int ADDR_W      = 19;
    localparam int MIN_BLOCK   = 32;

    typedef enum logic
    {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [0:0]        func;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0] result_address;
        logic              ok;
    } rsp_t;

endpackage

/* hw/rtl/ilffa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilffa_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/implicit_list_first_fit_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator
// Boundary-tag heap allocator, implicit list, first-fit search.
// ----------------------------------------------------------------------------
// One beat at a time. After reset an init sequence writes the prologue, the
// initial free chunk and the epilogue; no request is taken until it ends.
// An allocate walks the blocks first-fit, with one tag-store read for each
// block it visits, and closes the walk when it runs into the heap end; it
// then grows the heap if needed, writes the tags (header and footer, and a
// second pair when the block is split) and answers; a growth that does not
// fit goes straight to the answer. A release reads its own header, the
// previous footer and the next header, writes its own tags, and writes the
// merged tags when it merges with a free neighbor. A stalled result holds the
// block in its answer state. The tag store is a single-port-read memory with
// registered read data; that read per visited block sets the rate.
module implicit_list_first_fit_allocator #(
    parameter int HEAP_WORDS  = 65536,
    parameter int CHUNK_BYTES = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ilffa_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ilffa_pkg::rsp_t   rsp
);
    import ilffa_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int EW = (AW + 4 > 22) ? AW + 4 : 22;
    localparam int HEAP_BYTES_I = HEAP_WORDS * 8;
    localparam int INIT_SZ_I = (CHUNK_BYTES / 8) * 8 + ((CHUNK_BYTES / 8) % 2) * 8;
    localparam bit INIT_FIT = (INIT_SZ_I <= HEAP_BYTES_I - 32);
    localparam int INIT_END_I = INIT_FIT ? 32 + INIT_SZ_I : 32;
    localparam logic [EW-1:0] HEAP_BYTES = EW'(HEAP_BYTES_I);
    localparam logic [EW-1:0] CHUNK = EW'(CHUNK_BYTES);
    localparam logic [EW-1:0] INIT_SZ = EW'(INIT_SZ_I);
    localparam logic [EW-1:0] INIT_END = EW'(INIT_END_I);
    localparam logic [EW-1:0] MINB = EW'(MIN_BLOCK);

    typedef enum logic [20:0]
    {
        S_INIT   = 21'h000001,
        S_IDLE   = 21'h000002,
        S_FF_CHK = 21'h000004,
        S_FF_DAT = 21'h000008,
        S_GROW   = 21'h000010,
        S_G_PREV = 21'h000020,
        S_G_W1   = 21'h000040,
        S_G_W2   = 21'h000080,
        S_G_W3   = 21'h000100,
        S_PL_H   = 21'h000200,
        S_PL_F   = 21'h000400,
        S_PL_H2  = 21'h000800,
        S_PL_F2  = 21'h001000,
        S_R_HDR  = 21'h002000,
        S_R_PRV  = 21'h004000,
        S_R_NXT  = 21'h008000,
        S_R_W1   = 21'h010000,
        S_R_W2   = 21'h020000,
        S_R_W3   = 21'h040000,
        S_R_W4   = 21'h080000,
        S_RESP   = 21'h100000
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          init_cnt_reg, init_cnt_next;
    logic [EW-1:0]       heap_end_reg, heap_end_next;
    logic [EW-1:0]       cur_reg, cur_next;
    logic [EW-1:0]       asize_reg, asize_next;
    logic [EW-1:0]       bp_reg, bp_next;
    logic [EW-1:0]       cs_reg, cs_next;
    logic [EW-1:0]       sz_reg, sz_next;
    logic [EW-1:0]       psz_reg, psz_next;
    logic                pa_reg, pa_next;
    logic [EW-1:0]       m0a_reg, m0a_next, m0v_reg, m0v_next;
    logic [EW-1:0]       m1a_reg, m1a_next, m1v_reg, m1v_next;
    logic                mskip_reg, mskip_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                res_ok_reg, res_ok_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    logic                ram_we;
    logic [EW-1:0]       wbyte, wval, rbyte;
    logic                walloc;
    logic [TAG_W-1:0]    wtmp, ram_wdata, ram_rdata;
    logic [EW-1:0]       rd_size;
    logic                rd_alloc;
    logic [EW-1:0]       req_r, ext, gsz, nsz;

    assign rd_size  = EW'({ram_rdata[TAG_W-1:4], 4'b0000});
    assign rd_alloc = ram_rdata[0];
    assign wtmp      = TAG_W'(wval);
    assign ram_wdata = {wtmp[TAG_W-1:1], walloc};

    // growth size: max(asize, chunk) rounded up to an even word count
    assign ext = (asize_reg > CHUNK) ? asize_reg : CHUNK;
    assign gsz = {ext[EW-1:3], 3'b000} + (ext[3] ? EW'(8) : EW'(0));

    assign req_r = EW'(req.request_bytes) + EW'(31);
    assign nsz   = rd_size;

    ilffa_ram #(
        .WIDTH (TAG_W),
        .DEPTH (HEAP_WORDS)
    ) u_tags (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wbyte[AW+2:3]),
        .wdata (ram_wdata),
        .raddr (rbyte[AW+2:3]),
        .rdata (ram_rdata)
    );

    // next-state and tag-store access
    always_comb
    begin
        state_next     = state_reg;
        init_cnt_next  = init_cnt_reg;
        heap_end_next  = heap_end_reg;
        cur_next       = cur_reg;
        asize_next     = asize_reg;
        bp_next        = bp_reg;
        cs_next        = cs_reg;
        sz_next        = sz_reg;
        psz_next       = psz_reg;
        pa_next        = pa_reg;
        m0a_next       = m0a_reg;
        m0v_next       = m0v_reg;
        m1a_next       = m1a_reg;
        m1v_next       = m1v_reg;
        mskip_next     = mskip_reg;
        res_addr_next  = res_addr_reg;
        res_ok_next    = res_ok_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        wbyte          = '0;
        wval           = '0;
        walloc         = 1'b0;
        rbyte          = '0;

        case (state_reg)
            S_INIT:
            begin
                ram_we        = 1'b1;
                init_cnt_next = init_cnt_reg + 3'd1;
                case (init_cnt_reg)
                    3'd0:
                    begin
                        wbyte  = EW'(8);
                        wval   = EW'(16);
                        walloc = 1'b1;
                    end
                    3'd1:
                    begin
                        wbyte  = EW'(16);
                        wval   = EW'(16);
                        walloc = 1'b1;
                    end
                    3'd2:
                    begin
                        wbyte  = EW'(24);
                        wval   = INIT_FIT ? INIT_SZ : '0;
                        walloc = !INIT_FIT;
                        if (!INIT_FIT)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    3'd3:
                    begin
                        wbyte = INIT_SZ + EW'(16);
                        wval  = INIT_SZ;
                    end
                    default:
                    begin
                        wbyte      = INIT_SZ + EW'(24);
                        walloc     = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.func == FUNC_RELEASE)
                    begin
                        bp_next    = EW'(req.block_address);
                        rbyte      = EW'(req.block_address) - EW'(8);
                        state_next = S_R_HDR;
                    end
                    else if (req.request_bytes == '0)
                    begin
                        res_ok_next   = 1'b0;
                        res_addr_next = '0;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        asize_next = (req.request_bytes <= REQ_W'(16)) ? EW'(32)
                                   : {req_r[EW-1:4], 4'b0000};
                        cur_next   = EW'(16);
                        state_next = S_FF_CHK;
                    end
                end
            end

            // first-fit walk: one header read per block
            S_FF_CHK:
            begin
                if (cur_reg >= heap_end_reg)
                begin
                    state_next = S_GROW;
                end
                else
                begin
                    rbyte      = cur_reg - EW'(8);
                    state_next = S_FF_DAT;
                end
            end

            S_FF_DAT:
            begin
                if (rd_size == '0)
                begin
                    state_next = S_GROW;
                end
                else if (!rd_alloc && asize_reg <= rd_size)
                begin
                    bp_next    = cur_reg;
                    cs_next    = rd_size;
                    state_next = S_PL_H;
                end
                else
                begin
                    cur_next   = cur_reg + rd_size;
                    state_next = S_FF_CHK;
                end
            end

            // heap growth, then merge with a trailing free block
            S_GROW:
            begin
                if (gsz > HEAP_BYTES - heap_end_reg)
                begin
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    state_next    = S_RESP;
                end
                else
                begin
                    bp_next    = heap_end_reg;
                    sz_next    = gsz;
                    rbyte      = heap_end_reg - EW'(16);
                    state_next = S_G_PREV;
                end
            end

            S_G_PREV:
            begin
                psz_next   = rd_size;
                pa_next    = rd_alloc;
                ram_we     = 1'b1;
                wbyte      = bp_reg - EW'(8);
                wval       = sz_reg;
                state_next = S_G_W1;
            end

            S_G_W1:
            begin
                ram_we     = 1'b1;
                wbyte      = bp_reg + sz_reg - EW'(16);
                wval       = pa_reg ? sz_reg : sz_reg + psz_reg;
                state_next = S_G_W2;
            end

            S_G_W2:
            begin
                ram_we        = 1'b1;
                wbyte         = bp_reg + sz_reg - EW'(8);
                walloc        = 1'b1;
                heap_end_next = heap_end_reg + sz_reg;
                if (pa_reg)
                begin
                    cs_next    = sz_reg;
                    state_next = S_PL_H;
                end
                else
                begin
                    state_next = S_G_W3;
                end
            end

            S_G_W3:
            begin
                ram_we     = 1'b1;
                wbyte      = bp_reg - psz_reg - EW'(8);
                wval       = sz_reg + psz_reg;
                bp_next    = bp_reg - psz_reg;
                cs_next    = sz_reg + psz_reg;
                state_next = S_PL_H;
            end

            // placement, with a split when the rest is a full block
            S_PL_H:
            begin
                ram_we     = 1'b1;
                wbyte      = bp_reg - EW'(8);
                wval       = (cs_reg >= asize_reg + MINB) ? asize_reg : cs_reg;
                walloc     = 1'b1;
                state_next = S_PL_F;
            end

            S_PL_F:
            begin
                ram_we        = 1'b1;
                walloc        = 1'b1;
                res_ok_next   = 1'b1;
                res_addr_next = bp_reg[ADDR_W-1:0];
                if (cs_reg >= asize_reg + MINB)
                begin
                    wbyte      = bp_reg + asize_reg - EW'(16);
                    wval       = asize_reg;
                    state_next = S_PL_H2;
                end
                else
                begin
                    wbyte      = bp_reg + cs_reg - EW'(16);
                    wval       = cs_reg;
                    state_next = S_RESP;
                end
            end

            S_PL_H2:
            begin
                ram_we     = 1'b1;
                wbyte      = bp_reg + asize_reg - EW'(8);
                wval       = cs_reg - asize_reg;
                state_next = S_PL_F2;
            end

            S_PL_F2:
            begin
                ram_we     = 1'b1;
                wbyte      = bp_reg + cs_reg - EW'(16);
                wval       = cs_reg - asize_reg;
                state_next = S_RESP;
            end

            // release: read own header, previous footer, next header
            S_R_HDR:
            begin
                sz_next    = rd_size;
                rbyte      = bp_reg - EW'(16);
                state_next = S_R_PRV;
            end

            S_R_PRV:
            begin
                psz_next   = rd_size;
                pa_next    = rd_alloc;
                rbyte      = bp_reg + sz_reg - EW'(8);
                state_next = S_R_NXT;
            end

            S_R_NXT:
            begin
                mskip_next = pa_reg && rd_alloc;
                if (pa_reg)
                begin
                    m0a_next = bp_reg - EW'(8);
                    m0v_next = sz_reg + nsz;
                    m1a_next = bp_reg + sz_reg + nsz - EW'(16);
                    m1v_next = sz_reg + nsz;
                end
                else if (rd_alloc)
                begin
                    m0a_next = bp_reg + sz_reg - EW'(16);
                    m0v_next = sz_reg + psz_reg;
                    m1a_next = bp_reg - psz_reg - EW'(8);
                    m1v_next = sz_reg + psz_reg;
                end
                else
                begin
                    m0a_next = bp_reg - psz_reg - EW'(8);
                    m0v_next = sz_reg + psz_reg + nsz;
                    m1a_next = bp_reg + sz_reg + nsz - EW'(16);
                    m1v_next = sz_reg + psz_reg + nsz;
                end
                ram_we     = 1'b1;
                wbyte      = bp_reg - EW'(8);
                wval       = sz_reg;
                state_next = S_R_W1;
            end

            S_R_W1:
            begin
                ram_we        = 1'b1;
                wbyte         = bp_reg + sz_reg - EW'(16);
                wval          = sz_reg;
                res_ok_next   = 1'b1;
                res_addr_next = '0;
                state_next    = mskip_reg ? S_RESP : S_R_W2;
            end

            S_R_W2:
            begin
                ram_we     = 1'b1;
                wbyte      = m0a_reg;
                wval       = m0v_reg;
                state_next = S_R_W3;
            end

            S_R_W3:
            begin
                ram_we     = 1'b1;
                wbyte      = m1a_reg;
                wval       = m1v_reg;
                state_next = S_R_W4;
            end

            S_R_W4:
            begin
                state_next = S_RESP;
            end

            // hand the result to the output register
            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.result_address = res_addr_reg;
                    rsp_next.ok             = res_ok_reg;
                    state_next              = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_cnt_reg  <= '0;
            heap_end_reg  <= INIT_END;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_cnt_reg  <= init_cnt_next;
            heap_end_reg  <= heap_end_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        asize_reg    <= asize_next;
        bp_reg       <= bp_next;
        cs_reg       <= cs_next;
        sz_reg       <= sz_next;
        psz_reg      <= psz_next;
        pa_reg       <= pa_next;
        m0a_reg      <= m0a_next;
        m0v_reg      <= m0v_next;
        m1a_reg      <= m1a_next;
        m1v_reg      <= m1v_next;
        mskip_reg    <= mskip_next;
        res_addr_reg <= res_addr_next;
        res_ok_reg   <= res_ok_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* tb/implicit_list_first_fit_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator_tb
// Drives allocate and release beats into the first-fit heap allocator. A
// scoreboard keeps its own copy of the boundary-tag heap, predicts each
// answer and checks every response beat in order. Release beats only name
// live blocks. Both sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator_tb;
    import ilffa_pkg::*;

    localparam int           HEAP_WORDS  = 65536;
    localparam int           CHUNK_BYTES = 4096;
    localparam longint       CYCLE_LIMIT = 40000000;
    localparam bit [TAG_W-1:0] SIZE_BITS = 21'h1FFFF0;

    // ------------------------------------------------------------------------
    // Heap mirror and answer checker
    // ------------------------------------------------------------------------
    class heap_scoreboard;
        bit [TAG_W-1:0]    tags [HEAP_WORDS];
        longint unsigned   heap_top;
        rsp_t              answers [$];
        logic [ADDR_W-1:0] live_blocks [$];
        int                fails;

        function new();
            longint unsigned unused;
            fails = 0;
            foreach (tags[i])
            begin
                tags[i] = '0;
            end
            put_tag(8, 17);
            put_tag(16, 17);
            put_tag(24, 1);
            heap_top = 32;
            void'(extend(CHUNK_BYTES / 8, unused));
        endfunction

        function bit [TAG_W-1:0] get_tag(longint unsigned b);
            return tags[(b >> 3) % HEAP_WORDS];
        endfunction

        function void put_tag(longint unsigned b, longint unsigned v);
            tags[(b >> 3) % HEAP_WORDS] = v[TAG_W-1:0];
        endfunction

        function longint unsigned size_of(longint unsigned b);
            return get_tag(b) & SIZE_BITS;
        endfunction

        function bit used(longint unsigned b);
            bit [TAG_W-1:0] t;
            t = get_tag(b);
            return t[0];
        endfunction

        function longint unsigned foot(longint unsigned bp);
            return bp + size_of(bp - 8) - 16;
        endfunction

        function longint unsigned next_bp(longint unsigned bp);
            return bp + size_of(bp - 8);
        endfunction

        function longint unsigned prev_bp(longint unsigned bp);
            return bp - size_of(bp - 16);
        endfunction

        // coalesce with free neighbors
        function longint unsigned coalesce(longint unsigned bp);
            bit prev_used;
            bit next_used;
            longint unsigned sz;
            prev_used = used(foot(prev_bp(bp)));
            next_used = used(next_bp(bp) - 8);
            sz = size_of(bp - 8);
            if (prev_used && next_used)
                return bp;
            if (prev_used)
            begin
                sz += size_of(next_bp(bp) - 8);
                put_tag(bp - 8, sz);
                put_tag(foot(bp), sz);
            end
            else if (next_used)
            begin
                sz += size_of(prev_bp(bp) - 8);
                put_tag(foot(bp), sz);
                put_tag(prev_bp(bp) - 8, sz);
                bp = prev_bp(bp);
            end
            else
            begin
                sz += size_of(prev_bp(bp) - 8) + size_of(foot(next_bp(bp)));
                put_tag(prev_bp(bp) - 8, sz);
                put_tag(foot(next_bp(bp)), sz);
                bp = prev_bp(bp);
            end
            return bp;
        endfunction

        function bit extend(longint unsigned words, output longint unsigned bp);
            longint unsigned sz;
            sz = words * 8;
            bp = 0;
            if (words[0])
                sz += 8;
            if (sz > longint'(HEAP_WORDS) * 8 - heap_top)
                return 0;
            bp = heap_top;
            heap_top += sz;
            put_tag(bp - 8, sz);
            put_tag(foot(bp), sz);
            put_tag(next_bp(bp) - 8, 1);
            bp = coalesce(bp);
            return 1;
        endfunction

        function void carve(longint unsigned bp, longint unsigned asize);
            longint unsigned cs;
            cs = size_of(bp - 8);
            if (cs >= asize + MIN_BLOCK)
            begin
                put_tag(bp - 8, asize | 1);
                put_tag(foot(bp), asize | 1);
                bp = next_bp(bp);
                put_tag(bp - 8, cs - asize);
                put_tag(foot(bp), cs - asize);
            end
            else
            begin
                put_tag(bp - 8, cs | 1);
                put_tag(foot(bp), cs | 1);
            end
        endfunction

        function bit first_fit(longint unsigned asize, output longint unsigned bp);
            longint unsigned cur;
            cur = 16;
            bp = 0;
            while (cur < heap_top && size_of(cur - 8) > 0)
            begin
                if (!used(cur - 8) && asize <= size_of(cur - 8))
                begin
                    bp = cur;
                    return 1;
                end
                cur = next_bp(cur);
            end
            return 0;
        endfunction

        // accepted request beat: update the mirror, queue the answer
        function rsp_t note_request(req_t r);
            rsp_t e;
            longint unsigned bp;
            longint unsigned asize;
            longint unsigned addr;
            longint unsigned sz;
            bit ok;
            e = '0;
            bp = 0;
            if (func_t'(r.func) == FUNC_RELEASE)
            begin
                addr = r.block_address;
                sz = size_of(addr - 8);
                put_tag(addr - 8, sz);
                put_tag(foot(addr), sz);
                void'(coalesce(addr));
                foreach (live_blocks[i])
                begin
                    if (live_blocks[i] == r.block_address)
                    begin
                        live_blocks.delete(i);
                        break;
                    end
                end
                e.ok = 1'b1;
            end
            else
            begin
                ok = 0;
                if (r.request_bytes != 0)
                begin
                    asize = (r.request_bytes <= 16) ? 32
                          : ((longint'(r.request_bytes) + 31) / 16) * 16;
                    ok = first_fit(asize, bp);
                    if (!ok)
                        ok = extend(((asize > CHUNK_BYTES) ? asize : CHUNK_BYTES) / 8, bp);
                    if (ok)
                        carve(bp, asize);
                end
                if (ok)
                begin
                    e.result_address = bp[ADDR_W-1:0];
                    e.ok = 1'b1;
                    live_blocks.push_back(bp[ADDR_W-1:0]);
                end
            end
            answers.push_back(e);
            return e;
        endfunction

        task report_mismatch(string what, longint unsigned got, longint unsigned want);
            fails++;
            $display("mismatch %0t: %s got %0d want %0d", $time, what, got, want);
        endtask

        task check_answer(rsp_t got);
            rsp_t e;
            if (answers.size() == 0)
            begin
                report_mismatch("unexpected beat, address", got.result_address, 0);
                return;
            end
            e = answers.pop_front();
            if (got.result_address !== e.result_address)
                report_mismatch("result_address", got.result_address, e.result_address);
            if (got.ok !== e.ok)
                report_mismatch("ok", got.ok, e.ok);
        endtask
    endclass

    logic   clk;
    logic   rst_n;
    logic   req_valid;
    logic   req_stall;
    req_t   req;
    logic   rsp_valid;
    logic   rsp_stall;
    rsp_t   rsp;

    heap_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    longint         cycles;

    implicit_list_first_fit_allocator #(
        .HEAP_WORDS  (HEAP_WORDS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // response side: check accepted beats, stall at random
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_answer(rsp);
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // random filler for unused request fields
    function req_t rand_req();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[$bits(req_t)-1:0];
    endfunction

    // one request beat; waits for acceptance, then an optional idle gap
    task send_beat(input req_t r, output rsp_t predicted);
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        predicted = sb.note_request(r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            req       <= rand_req();
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task alloc_bytes(input int unsigned n, output logic [ADDR_W-1:0] addr);
        req_t r;
        rsp_t p;
        r = rand_req();
        r.func = FUNC_ALLOC;
        r.request_bytes = n[REQ_W-1:0];
        send_beat(r, p);
        addr = p.result_address;
    endtask

    task release_block(input logic [ADDR_W-1:0] addr);
        req_t r;
        rsp_t p;
        r = rand_req();
        r.func = FUNC_RELEASE;
        r.block_address = addr;
        send_beat(r, p);
    endtask

    task random_beat();
        logic [ADDR_W-1:0] a;
        int unsigned       pick;
        int unsigned       n;
        int                live;
        live = sb.live_blocks.size();
        if (live > 0 && ($urandom_range(99) < ((live > 60) ? 75 : 45)))
        begin
            release_block(sb.live_blocks[$urandom_range(live - 1)]);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                n = 0;
            else if (pick < 60)
                n = $urandom_range(64, 1);
            else if (pick < 85)
                n = $urandom_range(1024, 65);
            else if (pick < 97)
                n = $urandom_range(8192, 1025);
            else
                n = $urandom_range(1048575, 100000);
            alloc_bytes(n, a);
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] x, y, z, w;
        sb             = new();
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        rsp_stall      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: size extremes, rounding edges, growth and failure
        alloc_bytes(0, x);
        alloc_bytes(1, x);
        alloc_bytes(16, x);
        alloc_bytes(17, x);
        alloc_bytes(1048575, x);
        alloc_bytes(524288, x);
        alloc_bytes(4000, x);
        // coalesce cases: no free neighbor, free next neighbor, both neighbors free
        alloc_bytes(48, x);
        alloc_bytes(48, y);
        alloc_bytes(48, z);
        alloc_bytes(48, w);
        release_block(y);
        release_block(x);
        release_block(w);
        release_block(z);
        // large blocks push addresses into the top bits
        alloc_bytes(300000, x);
        alloc_bytes(200000, y);
        alloc_bytes(10000, z);
        release_block(x);
        release_block(y);
        release_block(z);

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 79 : (ph == 3) ? 22 : 0;
            recv_stall_pct = (ph == 2) ? 79 : (ph == 3) ? 22 : 0;
            repeat (345) random_beat();
        end

        req_valid <= 1'b0;
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
